@@ rtl/core/foc_frame_transform_chain_defines.svh @@
// ----------------------------------------------------------------------------
// foc_frame_transform_chain_defines.svh
// Assertion macros for the FOC frame transform chain.
// ----------------------------------------------------------------------------
`ifndef FOC_FRAME_TRANSFORM_CHAIN_DEFINES_SVH
`define FOC_FRAME_TRANSFORM_CHAIN_DEFINES_SVH

`ifndef SYNTHESIS

`define FFTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define FFTC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define FFTC_ASSERT(lbl, prop, msg)

`define FFTC_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ rtl/core/fftc_pkg.sv @@
// ----------------------------------------------------------------------------
// fftc_pkg
// Types, constants and rounding/saturation helpers of the transform chain.
// ----------------------------------------------------------------------------
package fftc_pkg;

  localparam int unsigned DataW  = 16;
  localparam int unsigned SumW   = 34;
  localparam int unsigned RndW   = SumW - 15;
  localparam int unsigned InW    = 9 * DataW;
  localparam int unsigned OutW   = 11 * DataW;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgCompSin = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCompCos = 2'd1;

  localparam logic signed [DataW-1:0] CompSinRst   = 16'sd0;
  localparam logic signed [DataW-1:0] CompCosRst   = 16'sd32767;
  localparam logic signed [DataW-1:0] InvSqrt3     = 16'sd18919;
  localparam logic signed [DataW-1:0] HalfSqrt3    = 16'sd28378;

  typedef logic signed [DataW-1:0] smp_t;
  typedef logic signed [RndW-1:0]  rnd_t;

  typedef struct packed {
    smp_t al;
    smp_t be;
    smp_t rs;
    smp_t rc;
    smp_t ps;
    smp_t pc;
    smp_t ud;
    smp_t uq;
  } s1_t;

  typedef struct packed {
    smp_t al;
    smp_t be;
    smp_t rs;
    smp_t rc;
    smp_t id;
    smp_t iq;
    smp_t sp;
    smp_t cp;
    smp_t ud;
    smp_t uq;
  } s2_t;

  typedef struct packed {
    smp_t al;
    smp_t be;
    smp_t rs;
    smp_t rc;
    smp_t id;
    smp_t iq;
    smp_t av;
    smp_t bv;
    smp_t pa;
    smp_t pb;
  } s3_t;

  // round half up: floor((x + 2^14) / 2^15)
  function automatic rnd_t rnd15(input logic signed [SumW-1:0] x);
    logic signed [SumW-1:0] t;
    t = x + SumW'(16384);
    return t[SumW-1:15];
  endfunction

  function automatic smp_t sat16(input rnd_t x);
    if (x > RndW'(32767)) begin
      return 16'sd32767;
    end else if (x < -RndW'(32768)) begin
      return -16'sd32768;
    end
    return x[DataW-1:0];
  endfunction

  function automatic smp_t satu(input rnd_t x);
    if (x > RndW'(32767)) begin
      return 16'sd32767;
    end else if (x < -RndW'(32767)) begin
      return -16'sd32767;
    end
    return x[DataW-1:0];
  endfunction

endpackage

@@ rtl/core/fftc_rot.sv @@
// ----------------------------------------------------------------------------
// fftc_rot
// Rotation kernel: p = x*c - y*s, q = x*s + y*c, each rounded to Q15.
// ----------------------------------------------------------------------------
module fftc_rot import fftc_pkg::*; (
  input  smp_t x_i,
  input  smp_t y_i,
  input  smp_t c_i,
  input  smp_t s_i,
  output rnd_t p_o,
  output rnd_t q_o
);

  logic signed [2*DataW-1:0] xc, ys, xs, yc;
  logic signed [SumW-1:0]    p_sum, q_sum;

  assign xc = x_i * c_i;
  assign ys = y_i * s_i;
  assign xs = x_i * s_i;
  assign yc = y_i * c_i;

  assign p_sum = SumW'(xc) - SumW'(ys);
  assign q_sum = SumW'(xs) + SumW'(yc);

  assign p_o = rnd15(p_sum);
  assign q_o = rnd15(q_sum);

endmodule

@@ rtl/core/foc_frame_transform_chain.sv @@
// ----------------------------------------------------------------------------
// foc_frame_transform_chain
// Clarke / Park / inverse Park / inverse Clarke chain, four pipeline stages.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake             | payload
//  s_axis   | in  | tvalid / tready       | tdata: 9 x 16b sample set
//  m_axis   | out | tvalid / tready       | tdata: 11 x 16b results
//  cfg      | in  | cfg_valid / cfg_ready | cfg_index, cfg_data (comp sin/cos)
//
//  One beat per cycle sustained while m_axis_tready_i stays high.
//  Stages: angle comp + Clarke, Park + predicted angle, inverse Park x2,
//  inverse Clarke (last stage is the output register).
//  Each stage holds while its successor is full and stalled.
//  Reset clears stage valids and loads comp_sin = 0, comp_cos = 32767.
// ----------------------------------------------------------------------------
`include "foc_frame_transform_chain_defines.svh"

module foc_frame_transform_chain import fftc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // ia, ib, ic, est_sin, est_cos, pred_sin, pred_cos, ud, uq (16b each)
  input  logic [InW-1:0]       s_axis_tdata_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // i_alpha, i_beta, real_sin, real_cos, id, iq, u_alpha, u_beta,
  // pred_a, pred_b, pred_c (16b each)
  output logic [OutW-1:0]      m_axis_tdata_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [DataW-1:0]     cfg_data_i
);

  // config
  smp_t comp_sin_q, comp_cos_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comp_sin_q <= CompSinRst;
      comp_cos_q <= CompCosRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgCompSin) begin
        comp_sin_q <= cfg_data_i;
      end
      if (cfg_index_i == CfgCompCos) begin
        comp_cos_q <= cfg_data_i;
      end
    end
  end

  // stage control
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_q || m_axis_tready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // stage 1: Clarke beta, angle compensation
  smp_t in_ia, in_ib, in_ic, in_es, in_ec, in_ps, in_pc, in_ud, in_uq;
  assign in_ia = s_axis_tdata_i[0*DataW +: DataW];
  assign in_ib = s_axis_tdata_i[1*DataW +: DataW];
  assign in_ic = s_axis_tdata_i[2*DataW +: DataW];
  assign in_es = s_axis_tdata_i[3*DataW +: DataW];
  assign in_ec = s_axis_tdata_i[4*DataW +: DataW];
  assign in_ps = s_axis_tdata_i[5*DataW +: DataW];
  assign in_pc = s_axis_tdata_i[6*DataW +: DataW];
  assign in_ud = s_axis_tdata_i[7*DataW +: DataW];
  assign in_uq = s_axis_tdata_i[8*DataW +: DataW];

  logic signed [DataW:0]     diff_bc;
  logic signed [2*DataW:0]   beta_prod;
  rnd_t                      r1_p, r1_q;
  s1_t                       s1_d, s1_q;

  assign diff_bc   = (DataW+1)'(in_ib) - (DataW+1)'(in_ic);
  assign beta_prod = diff_bc * InvSqrt3;

  fftc_rot u_rot_comp (
    .x_i (in_ec),
    .y_i (in_es),
    .c_i (comp_cos_q),
    .s_i (comp_sin_q),
    .p_o (r1_p),
    .q_o (r1_q)
  );

  always_comb begin
    s1_d.al = in_ia;
    s1_d.be = sat16(rnd15(SumW'(beta_prod)));
    s1_d.rs = satu(r1_q);
    s1_d.rc = satu(r1_p);
    s1_d.ps = in_ps;
    s1_d.pc = in_pc;
    s1_d.ud = in_ud;
    s1_d.uq = in_uq;
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) s1_q <= s1_d;
  end

  // stage 2: Park, predicted angle
  rnd_t r2a_p, r2a_q, r2b_p, r2b_q;
  s2_t  s2_d, s2_q;

  fftc_rot u_rot_park (
    .x_i (s1_q.be),
    .y_i (s1_q.al),
    .c_i (s1_q.rc),
    .s_i (s1_q.rs),
    .p_o (r2a_p),
    .q_o (r2a_q)
  );

  fftc_rot u_rot_pred (
    .x_i (s1_q.rc),
    .y_i (s1_q.rs),
    .c_i (s1_q.pc),
    .s_i (s1_q.ps),
    .p_o (r2b_p),
    .q_o (r2b_q)
  );

  always_comb begin
    s2_d.al = s1_q.al;
    s2_d.be = s1_q.be;
    s2_d.rs = s1_q.rs;
    s2_d.rc = s1_q.rc;
    s2_d.id = sat16(r2a_q);
    s2_d.iq = sat16(r2a_p);
    s2_d.sp = satu(r2b_q);
    s2_d.cp = satu(r2b_p);
    s2_d.ud = s1_q.ud;
    s2_d.uq = s1_q.uq;
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) s2_q <= s2_d;
  end

  // stage 3: inverse Park of currents and voltages
  rnd_t r3a_p, r3a_q, r3b_p, r3b_q;
  s3_t  s3_d, s3_q;

  fftc_rot u_rot_ipark_i (
    .x_i (s2_q.id),
    .y_i (s2_q.iq),
    .c_i (s2_q.cp),
    .s_i (s2_q.sp),
    .p_o (r3a_p),
    .q_o (r3a_q)
  );

  fftc_rot u_rot_ipark_u (
    .x_i (s2_q.ud),
    .y_i (s2_q.uq),
    .c_i (s2_q.cp),
    .s_i (s2_q.sp),
    .p_o (r3b_p),
    .q_o (r3b_q)
  );

  always_comb begin
    s3_d.al = s2_q.al;
    s3_d.be = s2_q.be;
    s3_d.rs = s2_q.rs;
    s3_d.rc = s2_q.rc;
    s3_d.id = s2_q.id;
    s3_d.iq = s2_q.iq;
    s3_d.av = sat16(r3b_p);
    s3_d.bv = sat16(r3b_q);
    s3_d.pa = sat16(r3a_p);
    s3_d.pb = sat16(r3a_q);
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) s3_q <= s3_d;
  end

  // stage 4: inverse Clarke, output register
  logic signed [2*DataW-1:0] pb_prod;
  logic signed [SumW-1:0]    pa_half, sum_b, sum_c;
  logic [OutW-1:0]           out_d, out_q;

  assign pb_prod = s3_q.pb * HalfSqrt3;
  assign pa_half = SumW'(s3_q.pa) <<< 14;
  assign sum_b   = SumW'(pb_prod) - pa_half;
  assign sum_c   = -SumW'(pb_prod) - pa_half;

  assign out_d = {sat16(rnd15(sum_c)), sat16(rnd15(sum_b)), s3_q.pa,
                  s3_q.bv, s3_q.av, s3_q.iq, s3_q.id,
                  s3_q.rc, s3_q.rs, s3_q.be, s3_q.al};

  always_ff @(posedge clk_i) begin
    if (rdy4) out_q <= out_d;
  end

  assign m_axis_tvalid_o = v4_q;
  assign m_axis_tdata_o  = out_q;

  // checks
  `FFTC_ASSERT(a_accept_fills_s1, s_axis_tvalid_i && s_axis_tready_o |=> v1_q, "accepted beat did not reach stage 1")
  `FFTC_ASSERT(a_s3_holds_on_stall, v3_q && !rdy4 |=> v3_q && $stable(s3_q), "stage 3 lost data on stall")
  `FFTC_ASSERT(a_real_sin_sym_sat, m_axis_tvalid_o |-> m_axis_tdata_o[2*DataW +: DataW] != 16'h8000, "real_sin outside symmetric range")
  `FFTC_ASSERT_ALWAYS(a_rst_clears_out, !rst_ni |-> !m_axis_tvalid_o, "output valid during reset")

endmodule

@@ test/tb_foc_frame_transform_chain.sv @@
// ----------------------------------------------------------------------------
// tb_foc_frame_transform_chain
// Self-checking bench for the FOC frame transform chain. A short directed
// table (zero, extreme and out-of-range trig inputs) is followed by phases of
// random sample sets, mostly balanced currents with unit angles and partly
// raw noise. Each phase sets its own compensation angle, extremes among them.
// Every accepted input beat but the typed directed rows is run through a fixed-point model in the bench.
// Each output beat is compared field by field with the oldest prediction.
// Sender gaps and receiver stalls vary by phase. One long receiver hold-off
// backs the pipeline up into its input.
// ----------------------------------------------------------------------------
module tb_foc_frame_transform_chain;
  timeunit 1ns;
  timeprecision 1ps;
  import fftc_pkg::*;

  localparam longint InvSqrt3Q  = 18919;
  localparam longint HalfSqrt3Q = 28378;
  localparam longint HalfQ      = 16384;
  localparam longint FullLo     = -32768;
  localparam longint TrigLo     = -32767;
  localparam int     NumPhases  = 8;
  localparam int     SetsPerPhase = 142;
  localparam int     HoldCycles = 300;
  localparam int     MaxShown   = 10;
  localparam real    Pi         = 3.14159265358979;

  localparam logic [CfgIdxW-1:0] CfgSpare2 = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpare3 = 2'd3;

  // ia sits in the low bits
  typedef struct packed {
    smp_t uq;
    smp_t ud;
    smp_t pred_cos;
    smp_t pred_sin;
    smp_t est_cos;
    smp_t est_sin;
    smp_t ic;
    smp_t ib;
    smp_t ia;
  } smp_set_t;

  // alpha_cur sits in the low bits
  typedef struct packed {
    smp_t pred_c;
    smp_t pred_b;
    smp_t pred_a;
    smp_t beta_v;
    smp_t alpha_v;
    smp_t q_cur;
    smp_t d_cur;
    smp_t real_cos;
    smp_t real_sin;
    smp_t beta_cur;
    smp_t alpha_cur;
  } frame_res_t;

  // typed rows expect the given alpha/beta currents and zero elsewhere
  typedef struct {
    smp_set_t smp;
    bit       typed;
    smp_t     alpha_cur;
    smp_t     beta_cur;
  } dir_row_t;

  typedef enum logic [1:0] {IdleNone, IdleTx, IdleRx, IdleBoth} idle_mode_e;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b1;
  logic                 s_valid   = 1'b0;
  smp_set_t             s_data    = '0;
  logic                 s_ready;
  logic                 m_valid;
  frame_res_t           m_data;
  logic                 m_ready   = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index = CfgCompSin;
  smp_t                 cfg_data  = '0;
  logic                 cfg_ready;

  logic                 hold_req   = 1'b0;
  logic                 hold_taken = 1'b0;
  int                   hold_left  = 0;
  int                   tx_pct     = 0;
  int                   rx_pct     = 0;
  int                   err_cnt    = 0;

  smp_t                 comp_sin_q = CompSinRst;
  smp_t                 comp_cos_q = CompCosRst;
  frame_res_t           frame_q[$];
  dir_row_t             dir_tab[$];

  string      res_name   [11] = '{"alpha_cur", "beta_cur", "real_sin", "real_cos", "d_cur",
                                  "q_cur", "alpha_v", "beta_v", "pred_a", "pred_b", "pred_c"};
  int         phase_sin  [NumPhases] = '{0, -32768, 32767, -32767, 23170, 0, -12540, 0};
  int         phase_cos  [NumPhases] = '{32767, -32768, 32767, 0, 23170, -32768, 30274, 0};
  idle_mode_e phase_mode [NumPhases] = '{IdleNone, IdleTx, IdleRx, IdleBoth,
                                         IdleNone, IdleTx, IdleRx, IdleBoth};

  foc_frame_transform_chain dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint rnd_q15(longint x);
    return (x + 64'sd16384) >>> 15;
  endfunction

  function automatic smp_t clip16(longint x, longint lo);
    if (x > 32767) return 16'sd32767;
    if (x < lo) return smp_t'(lo);
    return smp_t'(x);
  endfunction

  function automatic frame_res_t frame_predict(smp_set_t s, smp_t c_sin, smp_t c_cos);
    longint ia, ib, ic, es, ec, ps, pc, ud, uq, cs, cc;
    longint be, rs, rc, id, iq, sp, cp, pa, pb;
    frame_res_t r;
    ia = s.ia;
    ib = s.ib;
    ic = s.ic;
    es = s.est_sin;
    ec = s.est_cos;
    ps = s.pred_sin;
    pc = s.pred_cos;
    ud = s.ud;
    uq = s.uq;
    cs = c_sin;
    cc = c_cos;
    be = clip16(rnd_q15((ib - ic) * InvSqrt3Q), FullLo);
    rs = clip16(rnd_q15(es * cc + ec * cs), TrigLo);
    rc = clip16(rnd_q15(ec * cc - es * cs), TrigLo);
    id = clip16(rnd_q15(ia * rc + be * rs), FullLo);
    iq = clip16(rnd_q15(be * rc - ia * rs), FullLo);
    sp = clip16(rnd_q15(rs * pc + rc * ps), TrigLo);
    cp = clip16(rnd_q15(rc * pc - rs * ps), TrigLo);
    pa = clip16(rnd_q15(id * cp - iq * sp), FullLo);
    pb = clip16(rnd_q15(id * sp + iq * cp), FullLo);
    r.alpha_cur = s.ia;
    r.beta_cur  = smp_t'(be);
    r.real_sin  = smp_t'(rs);
    r.real_cos  = smp_t'(rc);
    r.d_cur     = smp_t'(id);
    r.q_cur     = smp_t'(iq);
    r.alpha_v   = clip16(rnd_q15(ud * cp - uq * sp), FullLo);
    r.beta_v    = clip16(rnd_q15(ud * sp + uq * cp), FullLo);
    r.pred_a    = smp_t'(pa);
    r.pred_b    = clip16(rnd_q15(-pa * HalfQ + pb * HalfSqrt3Q), FullLo);
    r.pred_c    = clip16(rnd_q15(-pa * HalfQ - pb * HalfSqrt3Q), FullLo);
    return r;
  endfunction

  function automatic smp_set_t mk_set(int ia, int ib, int ic, int es, int ec,
                                      int ps, int pc, int ud, int uq);
    smp_set_t s;
    s.ia       = smp_t'(ia);
    s.ib       = smp_t'(ib);
    s.ic       = smp_t'(ic);
    s.est_sin  = smp_t'(es);
    s.est_cos  = smp_t'(ec);
    s.pred_sin = smp_t'(ps);
    s.pred_cos = smp_t'(pc);
    s.ud       = smp_t'(ud);
    s.uq       = smp_t'(uq);
    return s;
  endfunction

  function automatic smp_t q15(real v);
    if (v > 32767.0) return 16'sd32767;
    if (v < -32768.0) return -16'sd32768;
    return smp_t'(int'(v));
  endfunction

  // mostly balanced currents on unit angles, a quarter raw noise
  function automatic smp_set_t rand_set();
    logic [8:0][DataW-1:0] noise;
    smp_set_t s;
    real th, adv, amp, ph;
    if ($urandom_range(99) < 25) begin
      for (int k = 0; k < 9; k++) noise[k] = DataW'($urandom);
      s = noise;
      return s;
    end
    th  = 2.0 * Pi * real'($urandom_range(65535)) / 65536.0;
    adv = (real'($urandom_range(2000)) - 1000.0) / 2000.0;
    amp = real'($urandom_range(32767));
    ph  = 2.0 * Pi * real'($urandom_range(65535)) / 65536.0;
    s.est_sin  = q15(32767.0 * $sin(th));
    s.est_cos  = q15(32767.0 * $cos(th));
    s.pred_sin = q15(32767.0 * $sin(adv));
    s.pred_cos = q15(32767.0 * $cos(adv));
    s.ia       = q15(amp * $cos(ph));
    s.ib       = q15(amp * $cos(ph - 2.0 * Pi / 3.0));
    s.ic       = q15(-real'(s.ia) - real'(s.ib));
    s.ud       = smp_t'($urandom);
    s.uq       = smp_t'($urandom);
    return s;
  endfunction

  task automatic note_error(string msg);
    err_cnt++;
    if (err_cnt <= MaxShown) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_beat(frame_res_t got);
    frame_res_t want;
    logic [10:0][DataW-1:0] gv, wv;
    if (frame_q.size() == 0) begin
      note_error($sformatf("result beat with nothing pending: %h", got));
      return;
    end
    want = frame_q.pop_front();
    gv = got;
    wv = want;
    for (int k = 0; k < 11; k++) begin
      if (gv[k] !== wv[k]) begin
        note_error($sformatf("%s expected %0d got %0d", res_name[k],
                             $signed(wv[k]), $signed(gv[k])));
      end
    end
  endtask

  task automatic send_set(smp_set_t smp, bit typed, smp_t al, smp_t be);
    frame_res_t fixed;
    while (tx_pct != 0 && $urandom_range(99) < tx_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= smp;
    do @(posedge clk); while (!s_ready);
    fixed = '0;
    fixed.alpha_cur = al;
    fixed.beta_cur  = be;
    frame_q.push_back(typed ? fixed : frame_predict(smp, comp_sin_q, comp_cos_q));
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
  endtask

  // cfg_valid stays up between back-to-back writes
  task automatic write_reg(logic [CfgIdxW-1:0] idx, smp_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CfgCompSin: comp_sin_q = val;
      CfgCompCos: comp_cos_q = val;
      default: ;
    endcase
  endtask

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    m_ready <= rst_n && (hold_left == 0) && !(hold_req && !hold_taken) &&
               ($urandom_range(99) >= rx_pct);
  end

  always @(posedge clk) begin
    if (rst_n && m_valid && m_ready) check_beat(m_data);
  end

  initial begin : stimulus
    smp_t cs, cc;
    // falling edge at time zero so the async reset is seen before the first clock
    rst_n <= 1'b0;
    dir_tab.push_back('{mk_set(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, 16'sd0, 16'sd0});
    dir_tab.push_back('{mk_set(-32768, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, -16'sd32768, 16'sd0});
    dir_tab.push_back('{mk_set(0, 32767, -32768, 0, 0, 0, 0, 0, 0), 1'b1, 16'sd0, 16'sd32767});
    dir_tab.push_back('{mk_set(0, -32768, 32767, 0, 0, 0, 0, 0, 0), 1'b1, 16'sd0, -16'sd32768});
    dir_tab.push_back('{mk_set(32767, -16384, -16383, 0, 32767, 0, 32767, 32767, -32768),
                        1'b0, 16'sd0, 16'sd0});
    dir_tab.push_back('{mk_set(-32768, 32767, -32768, -32768, -32768, -32768, -32768,
                               -32768, -32768), 1'b0, 16'sd0, 16'sd0});
    dir_tab.push_back('{mk_set(32767, 32767, -32768, 32767, 32767, 32767, 32767,
                               32767, 32767), 1'b0, 16'sd0, 16'sd0});
    dir_tab.push_back('{mk_set(20000, 20000, 20000, 23170, 23170, 12540, 30274, 1000, -2000),
                        1'b0, 16'sd0, 16'sd0});
    dir_tab.push_back('{mk_set(-12345, 5000, 7345, 32767, 0, -32767, 0, -32768, 32767),
                        1'b0, 16'sd0, 16'sd0});
    dir_tab.push_back('{mk_set(32767, -32768, 32767, -32767, 0, 32767, 0, 32767, -32768),
                        1'b0, 16'sd0, 16'sd0});
    dir_tab.push_back('{mk_set(21845, 21845, 21845, 21845, 21845, 21845, 21845, 21845, 21845),
                        1'b0, 16'sd0, 16'sd0});
    dir_tab.push_back('{mk_set(-21846, -21846, -21846, -21846, -21846, -21846, -21846,
                               -21846, -21846), 1'b0, 16'sd0, 16'sd0});
    dir_tab.push_back('{mk_set(0, 0, 0, 0, 32767, 0, 32767, -32768, -32768),
                        1'b0, 16'sd0, 16'sd0});
    dir_tab.push_back('{mk_set(32767, 32767, 32767, 0, -32767, 0, -32767, 32767, 32767),
                        1'b0, 16'sd0, 16'sd0});

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      send_set(dir_tab[i].smp, dir_tab[i].typed, dir_tab[i].alpha_cur, dir_tab[i].beta_cur);
    end

    for (int p = 0; p < NumPhases; p++) begin
      drain();
      tx_pct = (phase_mode[p] == IdleTx) ? 61 : (phase_mode[p] == IdleBoth) ? 17 : 0;
      rx_pct = (phase_mode[p] == IdleRx) ? 61 : (phase_mode[p] == IdleBoth) ? 17 : 0;
      cs = smp_t'(phase_sin[p]);
      cc = smp_t'(phase_cos[p]);
      if (p == NumPhases - 1) begin
        cs = smp_t'($urandom);
        cc = smp_t'($urandom);
      end
      write_reg(CfgCompSin, cs);
      write_reg(CfgCompCos, cc);
      // spare indexes must leave the angle untouched
      if (p == 1 || p == 6) begin
        write_reg(CfgSpare2, smp_t'($urandom));
        write_reg(CfgSpare3, smp_t'($urandom));
      end
      cfg_valid <= 1'b0;
      if (p == 0) hold_req <= 1'b1;
      for (int n = 0; n < SetsPerPhase; n++) send_set(rand_set(), 1'b0, 16'sd0, 16'sd0);
    end

    drain();
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_foc_frame_transform_chain OK");
    end else begin
      $display("tb_foc_frame_transform_chain NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("tb_foc_frame_transform_chain NOT OK");
    $finish;
  end

endmodule
